FILE: rtl/i2c_mbc_pkg.sv
// ----------------------------------------------------------------------------
// I2C master bit controller package
// Bus phase codes, command codes, register indexes and the result record.
// ----------------------------------------------------------------------------
package i2c_mbc_pkg;

	// command codes carried by req_type
	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_STOP  = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;
	localparam logic [1:0] CMD_READ  = 2'd3;

	// register indexes (byte address bit 2)
	localparam logic REG_SHORT_HOLD = 1'b0;
	localparam logic REG_LONG_HOLD  = 1'b1;

	localparam logic [15:0] SHORT_HOLD_RESET = 16'd2;
	localparam logic [15:0] LONG_HOLD_RESET  = 16'd5;

	localparam int          BYTE_BITS = 8;
	localparam logic [3:0]  LAST_BIT  = 4'd8;

	typedef enum logic [17:0] {
		PH_IDLE    = 18'h00001,
		PH_ST_A    = 18'h00002,
		PH_ST_B    = 18'h00004,
		PH_ST_C    = 18'h00008,
		PH_SP_A    = 18'h00010,
		PH_SP_B    = 18'h00020,
		PH_SP_C    = 18'h00040,
		PH_WR_SET  = 18'h00080,
		PH_WR_HIGH = 18'h00100,
		PH_WR_LOW  = 18'h00200,
		PH_AK_SET  = 18'h00400,
		PH_AK_HIGH = 18'h00800,
		PH_AK_LOW  = 18'h01000,
		PH_RD_HIGH = 18'h02000,
		PH_RD_LOW  = 18'h04000,
		PH_RA_SET  = 18'h08000,
		PH_RA_HIGH = 18'h10000,
		PH_RA_LOW  = 18'h20000
	} phase_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       sda_drive;
		logic       busy_res;
		logic       cmd_done;
		logic [7:0] read_byte;
		logic       slave_acked;
	} res_t;

endpackage

FILE: rtl/i2c_master_bit_controller.sv
// ----------------------------------------------------------------------------
// I2C master bit controller
// Tick-driven I2C master: start, stop, write byte with ACK sampling, read byte
// with ACK/NACK, every bus phase timed by the short and long hold counts.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the tick channel (tick_valid/tick_stall) is one tick of
//   the timing base and carries cmd_valid, req_type, write_data, send_ack and
//   the sampled sda_in. A command is taken only while the controller is idle.
//   Every tick yields exactly one result on the res channel (res_valid/
//   res_stall): the line levels, busy and done flags, last read byte and the
//   slave ACK, all as they stand after that tick.
//   The result is registered; one tick is taken every cycle while tick_stall
//   is low, the bus state being updated in a single register stage.
//   A result register and a skid register sit on the output, so a tick is
//   still taken while one result waits; tick_stall rises only once both hold
//   a result, and drops on the cycle after the receiver takes one.
//   Hold counts are written over APB (0x0 short, 0x4 long) by the user only
//   while idle; the block does not enforce it. Reset: SCL and SDA driven high,
//   controller idle, hold counts 2 and 5 ticks, both output registers empty.
// ----------------------------------------------------------------------------
module i2c_master_bit_controller #(
	parameter int HOLD_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// tick channel
	input  logic        tick_valid,
	output logic        tick_stall,
	input  logic        cmd_valid,
	input  logic [1:0]  req_type,
	input  logic [7:0]  write_data,
	input  logic        send_ack,
	input  logic        sda_in,
	// result channel
	output logic        res_valid,
	input  logic        res_stall,
	output logic        scl_out,
	output logic        sda_out,
	output logic        sda_drive,
	output logic        busy_res,
	output logic        cmd_done,
	output logic [7:0]  read_byte,
	output logic        slave_acked
);
	import i2c_mbc_pkg::*;

	logic [15:0] short_hold_q, long_hold_q;

	phase_t                phase_q, phase_n;
	logic [3:0]            bit_count_q, bit_count_n;
	logic [HOLD_WIDTH-1:0] hold_q, hold_n, hold_dec;
	logic [7:0]            shift_q, shift_n;
	logic                  ack_choice_q, ack_choice_n;
	logic                  scl_q, scl_n;
	logic                  sda_q, sda_n;
	logic                  sda_en_q, sda_en_n;
	logic                  ack_seen_q, ack_seen_n;
	logic [7:0]            last_read_q, last_read_n;
	logic                  done_n;
	logic                  do_enter;
	phase_t                enter_ph;
	logic                  enter_long;

	logic                  accept, take;
	res_t                  res_new, res_q, skid_q;
	logic                  res_valid_q, skid_valid_q;

	function automatic logic [HOLD_WIDTH-1:0] hold_len(input logic [15:0] v);
		logic [HOLD_WIDTH-1:0] t;
		t = HOLD_WIDTH'(v);
		return (t == '0) ? HOLD_WIDTH'(1) : t;
	endfunction

	// ---------------------------------------------------------------- config
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_hold_q <= SHORT_HOLD_RESET;
			long_hold_q  <= LONG_HOLD_RESET;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				REG_SHORT_HOLD: short_hold_q <= pwdata[15:0];
				REG_LONG_HOLD:  long_hold_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_SHORT_HOLD: prdata = {16'd0, short_hold_q};
			REG_LONG_HOLD:  prdata = {16'd0, long_hold_q};
			default:        prdata = '0;
		endcase
	end

	// ------------------------------------------------------------ bus engine
	assign hold_dec = (hold_q != '0) ? hold_q - HOLD_WIDTH'(1) : hold_q;

	always_comb begin
		phase_n      = phase_q;
		bit_count_n  = bit_count_q;
		hold_n       = hold_q;
		shift_n      = shift_q;
		ack_choice_n = ack_choice_q;
		scl_n        = scl_q;
		sda_n        = sda_q;
		sda_en_n     = sda_en_q;
		ack_seen_n   = ack_seen_q;
		last_read_n  = last_read_q;
		done_n       = 1'b0;
		do_enter     = 1'b0;
		enter_ph     = PH_IDLE;
		enter_long   = 1'b0;

		if (phase_q == PH_IDLE) begin
			if (cmd_valid) begin
				bit_count_n = '0;
				do_enter    = 1'b1;
				case (req_type)
					CMD_START: enter_ph = PH_ST_A;
					CMD_STOP:  enter_ph = PH_SP_A;
					CMD_WRITE: begin
						shift_n  = write_data;
						enter_ph = PH_WR_SET;
					end
					default: begin
						shift_n      = '0;
						ack_choice_n = send_ack;
						enter_ph     = PH_RD_HIGH;
					end
				endcase
			end
		end else begin
			hold_n = hold_dec;
			if (hold_dec == '0) begin
				do_enter = 1'b1;
				case (phase_q)
					PH_ST_A:    enter_ph = PH_ST_B;
					PH_ST_B:    enter_ph = PH_ST_C;
					PH_SP_A:    enter_ph = PH_SP_B;
					PH_SP_B:    enter_ph = PH_SP_C;
					PH_WR_SET:  enter_ph = PH_WR_HIGH;
					PH_WR_HIGH: enter_ph = PH_WR_LOW;
					PH_WR_LOW: begin
						bit_count_n = bit_count_q + 4'd1;
						enter_ph    = (bit_count_n < LAST_BIT) ? PH_WR_SET : PH_AK_SET;
					end
					PH_AK_SET:  enter_ph = PH_AK_HIGH;
					PH_AK_HIGH: begin
						ack_seen_n = ~sda_in;
						enter_ph   = PH_AK_LOW;
					end
					PH_RD_HIGH: begin
						shift_n  = {shift_q[BYTE_BITS-2:0], sda_in};
						enter_ph = PH_RD_LOW;
					end
					PH_RD_LOW: begin
						bit_count_n = bit_count_q + 4'd1;
						enter_ph    = (bit_count_n < LAST_BIT) ? PH_RD_HIGH : PH_RA_SET;
					end
					PH_RA_SET:  enter_ph = PH_RA_HIGH;
					PH_RA_HIGH: enter_ph = PH_RA_LOW;
					PH_RA_LOW: begin
						// release SDA and publish the byte
						do_enter    = 1'b0;
						done_n      = 1'b1;
						sda_en_n    = 1'b0;
						sda_n       = 1'b1;
						last_read_n = shift_q;
					end
					default: begin
						do_enter = 1'b0;
						done_n   = 1'b1;
					end
				endcase
				if (done_n) begin
					phase_n = PH_IDLE;
					hold_n  = '0;
				end
			end
		end

		// drive the lines for the phase being entered
		if (do_enter) begin
			case (enter_ph)
				PH_ST_A: begin
					sda_en_n = 1'b1; sda_n = 1'b1; scl_n = 1'b1; enter_long = 1'b1;
				end
				PH_ST_B: begin
					sda_n = 1'b0; enter_long = 1'b1;
				end
				PH_ST_C: begin
					scl_n = 1'b0; enter_long = 1'b1;
				end
				PH_SP_A: begin
					sda_en_n = 1'b1; scl_n = 1'b0; sda_n = 1'b0; enter_long = 1'b1;
				end
				PH_SP_B: begin
					scl_n = 1'b1; enter_long = 1'b1;
				end
				PH_SP_C: begin
					sda_n = 1'b1; enter_long = 1'b1;
				end
				PH_WR_SET: begin
					sda_en_n = 1'b1;
					sda_n    = shift_n[BYTE_BITS-1];
					shift_n  = {shift_n[BYTE_BITS-2:0], 1'b0};
				end
				PH_WR_HIGH, PH_AK_HIGH, PH_RA_HIGH: begin
					scl_n = 1'b1; enter_long = 1'b1;
				end
				PH_WR_LOW, PH_AK_LOW, PH_RD_LOW, PH_RA_LOW: scl_n = 1'b0;
				PH_AK_SET: begin
					sda_en_n = 1'b0; sda_n = 1'b1;
				end
				PH_RD_HIGH: begin
					sda_en_n = 1'b0; sda_n = 1'b1; scl_n = 1'b1;
				end
				PH_RA_SET: begin
					sda_en_n = 1'b1; sda_n = ~ack_choice_q;
				end
				default: ;
			endcase
			phase_n = enter_ph;
			hold_n  = hold_len(enter_long ? long_hold_q : short_hold_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			bit_count_q  <= '0;
			hold_q       <= '0;
			shift_q      <= '0;
			ack_choice_q <= 1'b0;
			scl_q        <= 1'b1;
			sda_q        <= 1'b1;
			sda_en_q     <= 1'b1;
			ack_seen_q   <= 1'b0;
			last_read_q  <= '0;
		end else if (accept) begin
			phase_q      <= phase_n;
			bit_count_q  <= bit_count_n;
			hold_q       <= hold_n;
			shift_q      <= shift_n;
			ack_choice_q <= ack_choice_n;
			scl_q        <= scl_n;
			sda_q        <= sda_n;
			sda_en_q     <= sda_en_n;
			ack_seen_q   <= ack_seen_n;
			last_read_q  <= last_read_n;
		end
	end

	// -------------------------------------------------------- result staging
	always_comb begin
		res_new.scl_out     = scl_n;
		res_new.sda_out     = sda_n;
		res_new.sda_drive   = sda_en_n;
		res_new.busy_res    = (phase_n != PH_IDLE);
		res_new.cmd_done    = done_n;
		res_new.read_byte   = last_read_n;
		res_new.slave_acked = ack_seen_n;
	end

	assign tick_stall = skid_valid_q;
	assign accept     = tick_valid && !tick_stall;
	assign take       = res_valid_q && !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (take || !res_valid_q) begin
			if (skid_valid_q) begin
				res_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				res_valid_q  <= accept;
			end
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take || !res_valid_q) begin
			if (skid_valid_q)
				res_q <= skid_q;
			else if (accept)
				res_q <= res_new;
		end else if (accept) begin
			skid_q <= res_new;
		end
	end

	assign res_valid   = res_valid_q;
	assign scl_out     = res_q.scl_out;
	assign sda_out     = res_q.sda_out;
	assign sda_drive   = res_q.sda_drive;
	assign busy_res    = res_q.busy_res;
	assign cmd_done    = res_q.cmd_done;
	assign read_byte   = res_q.read_byte;
	assign slave_acked = res_q.slave_acked;

	// ------------------------------------------------------------ assertions
	a_phase_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(phase_q))
		else $error("bus phase register not one-hot");

	a_skid_behind_res: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> res_valid_q)
		else $error("skid register full while result register empty");

	a_skid_held: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && !take |=> skid_valid_q && $stable(skid_q))
		else $error("waiting result lost from skid register");

	a_cmd_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd_valid && phase_q == PH_IDLE |=> phase_q != PH_IDLE)
		else $error("command taken while idle did not start");
endmodule

FILE: tb/sv/i2c_master_bit_controller_test.sv
// ----------------------------------------------------------------------------
// I2C master bit controller testbench
// Every handshaked tick is run through a local bus model. Each line state that
// comes out is compared with the oldest one the model predicted. A short
// table of commands comes first, with the results that are plain to see typed
// in. Random commands follow over a range of hold counts, written over APB
// while the controller is idle. Random stalls fall on both channels.
// ----------------------------------------------------------------------------
module i2c_master_bit_controller_test;
	timeunit 1ns;
	timeprecision 1ps;

	import i2c_mbc_pkg::*;

	// how sda_in is driven while a table row runs
	localparam logic [1:0] SDA_LOW  = 2'd0;
	localparam logic [1:0] SDA_HIGH = 2'd1;
	localparam logic [1:0] SDA_RAND = 2'd2;

	// allowed commands, one bit per command code
	localparam logic [3:0] ANY_CMD    = 4'b1111;
	localparam logic [3:0] ONLY_READ  = 4'b1000;
	localparam logic [3:0] START_STOP = 4'b0011;

	typedef struct packed {
		logic       cv;
		logic [1:0] req;
		logic [7:0] wd;
		logic       ack;
		logic       sda;
	} tick_t;

	typedef struct packed {
		logic       offer;
		logic [1:0] req;
		logic [7:0] wd;
		logic       ack;
		logic [1:0] sda_mode;
		logic       noise;
		logic       typed;
		res_t       want;
	} step_row_t;

	typedef struct packed {
		logic [31:0] short_raw;
		logic [31:0] long_raw;
		int          ncmd;
		logic [3:0]  mask;
	} hold_plan_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        tick_valid = 1'b0;
	logic        tick_stall;
	logic        cmd_valid = 1'b0;
	logic [1:0]  req_type = CMD_START;
	logic [7:0]  write_data = '0;
	logic        send_ack = 1'b0;
	logic        sda_in = 1'b1;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic        scl_out;
	logic        sda_out;
	logic        sda_drive;
	logic        busy_res;
	logic        cmd_done;
	logic [7:0]  read_byte;
	logic        slave_acked;

	i2c_master_bit_controller u_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// bus model state, as left by the last accepted tick
	phase_t      ph = PH_IDLE;
	logic [3:0]  bits_done = '0;
	int          ticks_left = 0;
	logic [7:0]  shreg = '0;
	logic        ack_pick = 1'b0;
	logic        scl_q = 1'b1;
	logic        sda_q = 1'b1;
	logic        drv_q = 1'b1;
	logic        ack_q = 1'b0;
	logic [7:0]  rd_q = '0;
	logic [15:0] short_ticks = SHORT_HOLD_RESET;
	logic [15:0] long_ticks = LONG_HOLD_RESET;

	res_t        line_state_q[$];
	int          mismatches = 0;
	int          results_taken = 0;
	int          stall_left = 0;
	int          send_idle_pct = 28;
	int          recv_idle_pct = 45;

	step_row_t   plan [14];
	hold_plan_t  sched [9];

	function automatic int hold_for(logic lng);
		logic [15:0] v;
		v = lng ? long_ticks : short_ticks;
		return (v == 16'd0) ? 1 : int'(v);
	endfunction

	function automatic void enter_phase(phase_t p);
		logic lng;
		lng = 1'b0;
		case (p)
			PH_ST_A: begin
				drv_q = 1'b1; sda_q = 1'b1; scl_q = 1'b1; lng = 1'b1;
			end
			PH_ST_B: begin
				sda_q = 1'b0; lng = 1'b1;
			end
			PH_ST_C, PH_SP_A: begin
				if (p == PH_SP_A) begin
					drv_q = 1'b1; sda_q = 1'b0;
				end
				scl_q = 1'b0; lng = 1'b1;
			end
			PH_SP_B, PH_WR_HIGH, PH_AK_HIGH, PH_RA_HIGH: begin
				scl_q = 1'b1; lng = 1'b1;
			end
			PH_SP_C: begin
				sda_q = 1'b1; lng = 1'b1;
			end
			PH_WR_SET: begin
				drv_q = 1'b1;
				sda_q = shreg[7];
				shreg = {shreg[6:0], 1'b0};
			end
			PH_WR_LOW, PH_AK_LOW, PH_RD_LOW, PH_RA_LOW: begin
				scl_q = 1'b0;
			end
			PH_AK_SET: begin
				drv_q = 1'b0; sda_q = 1'b1;
			end
			PH_RD_HIGH: begin
				drv_q = 1'b0; sda_q = 1'b1; scl_q = 1'b1;
			end
			PH_RA_SET: begin
				drv_q = 1'b1; sda_q = !ack_pick;
			end
			default: begin
			end
		endcase
		ph = p;
		ticks_left = hold_for(lng);
	endfunction

	// close the current phase; 1 once the command is complete
	function automatic logic end_phase(logic sda_now);
		case (ph)
			PH_ST_A:    enter_phase(PH_ST_B);
			PH_ST_B:    enter_phase(PH_ST_C);
			PH_SP_A:    enter_phase(PH_SP_B);
			PH_SP_B:    enter_phase(PH_SP_C);
			PH_WR_SET:  enter_phase(PH_WR_HIGH);
			PH_WR_HIGH: enter_phase(PH_WR_LOW);
			PH_WR_LOW: begin
				bits_done = bits_done + 4'd1;
				if (bits_done < LAST_BIT)
					enter_phase(PH_WR_SET);
				else
					enter_phase(PH_AK_SET);
			end
			PH_AK_SET: enter_phase(PH_AK_HIGH);
			PH_AK_HIGH: begin
				ack_q = !sda_now;
				enter_phase(PH_AK_LOW);
			end
			PH_RD_HIGH: begin
				shreg = {shreg[6:0], sda_now};
				enter_phase(PH_RD_LOW);
			end
			PH_RD_LOW: begin
				bits_done = bits_done + 4'd1;
				if (bits_done < LAST_BIT)
					enter_phase(PH_RD_HIGH);
				else
					enter_phase(PH_RA_SET);
			end
			PH_RA_SET:  enter_phase(PH_RA_HIGH);
			PH_RA_HIGH: enter_phase(PH_RA_LOW);
			PH_RA_LOW: begin
				drv_q = 1'b0;
				sda_q = 1'b1;
				rd_q = shreg;
				return 1'b1;
			end
			default: return 1'b1;
		endcase
		return 1'b0;
	endfunction

	function automatic res_t bus_tick(tick_t t);
		res_t r;
		logic fin;
		fin = 1'b0;
		if (ph == PH_IDLE) begin
			if (t.cv) begin
				bits_done = '0;
				case (t.req)
					CMD_START: enter_phase(PH_ST_A);
					CMD_STOP:  enter_phase(PH_SP_A);
					CMD_WRITE: begin
						shreg = t.wd;
						enter_phase(PH_WR_SET);
					end
					default: begin
						shreg = '0;
						ack_pick = t.ack;
						enter_phase(PH_RD_HIGH);
					end
				endcase
			end
		end else begin
			if (ticks_left > 0)
				ticks_left--;
			if (ticks_left == 0 && end_phase(t.sda)) begin
				ph = PH_IDLE;
				ticks_left = 0;
				fin = 1'b1;
			end
		end
		r.scl_out = scl_q;
		r.sda_out = sda_q;
		r.sda_drive = drv_q;
		r.busy_res = (ph != PH_IDLE);
		r.cmd_done = fin;
		r.read_byte = rd_q;
		r.slave_acked = ack_q;
		return r;
	endfunction

	// offer one tick, wait for it to be taken, then queue its line state;
	// a typed value replaces the prediction whenever it shows the bus idle
	task automatic push_tick(input tick_t t, input logic typed, input res_t typed_val);
		int gap;
		res_t r;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap != 0) begin
			tick_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tick_valid <= 1'b1;
		cmd_valid <= t.cv;
		req_type <= t.req;
		write_data <= t.wd;
		send_ack <= t.ack;
		sda_in <= t.sda;
		@(posedge clk);
		while (tick_stall)
			@(posedge clk);
		r = bus_tick(t);
		if (typed && !r.busy_res)
			r = typed_val;
		line_state_q.push_back(r);
	endtask

	task automatic cfg_write(input logic idx, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_SHORT_HOLD)
			short_ticks = data[15:0];
		else
			long_ticks = data[15:0];
	endtask

	always @(posedge clk) begin : line_monitor
		res_t got;
		res_t want;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				got.scl_out = scl_out;
				got.sda_out = sda_out;
				got.sda_drive = sda_drive;
				got.busy_res = busy_res;
				got.cmd_done = cmd_done;
				got.read_byte = read_byte;
				got.slave_acked = slave_acked;
				if (line_state_q.size() == 0) begin
					$display("%0t: line state with none expected: got %p", $time, got);
					mismatches++;
				end else begin
					want = line_state_q.pop_front();
					if (got.scl_out !== want.scl_out || got.sda_out !== want.sda_out
							|| got.sda_drive !== want.sda_drive
							|| got.busy_res !== want.busy_res
							|| got.cmd_done !== want.cmd_done
							|| got.read_byte !== want.read_byte
							|| got.slave_acked !== want.slave_acked) begin
						$display("%0t: line state mismatch: expected %p, got %p",
							$time, want, got);
						mismatches++;
					end
				end
				results_taken++;
				// hold off long enough for the output registers to fill
				if (results_taken == 300)
					stall_left = 200;
			end
			res_stall <= (stall_left != 0) || ($urandom_range(99) < recv_idle_pct);
			if (stall_left != 0)
				stall_left--;
		end
	end

	initial begin
		#40_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		tick_t t;
		step_row_t row;
		int taken;
		logic idle_now;

		// want: {scl, sda, drive, busy, done, read_byte, slave_acked}
		plan[0]  = '{1'b0, CMD_START, 8'h00, 1'b0, SDA_HIGH, 1'b0, 1'b1,
			{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0}};
		plan[1]  = '{1'b1, CMD_START, 8'h00, 1'b0, SDA_HIGH, 1'b0, 1'b1,
			{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0}};
		plan[2]  = '{1'b1, CMD_WRITE, 8'hFF, 1'b0, SDA_LOW, 1'b0, 1'b1,
			{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 8'h00, 1'b1}};
		plan[3]  = '{1'b1, CMD_WRITE, 8'h00, 1'b1, SDA_HIGH, 1'b0, 1'b1,
			{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0}};
		plan[4]  = '{1'b1, CMD_READ, 8'h00, 1'b1, SDA_HIGH, 1'b0, 1'b1,
			{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 8'hFF, 1'b0}};
		plan[5]  = '{1'b1, CMD_READ, 8'hFF, 1'b0, SDA_LOW, 1'b0, 1'b1,
			{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0}};
		plan[6]  = '{1'b1, CMD_STOP, 8'h00, 1'b0, SDA_LOW, 1'b0, 1'b1,
			{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0}};
		// in the next six rows random commands also arrive while busy and must be dropped
		plan[7]  = '{1'b1, CMD_START, 8'h00, 1'b0, SDA_RAND, 1'b1, 1'b0, '0};
		plan[8]  = '{1'b1, CMD_WRITE, 8'h5A, 1'b0, SDA_RAND, 1'b1, 1'b0, '0};
		plan[9]  = '{1'b1, CMD_READ, 8'h00, 1'b1, SDA_RAND, 1'b1, 1'b0, '0};
		plan[10] = '{1'b1, CMD_WRITE, 8'h81, 1'b1, SDA_RAND, 1'b1, 1'b0, '0};
		plan[11] = '{1'b1, CMD_READ, 8'h00, 1'b0, SDA_RAND, 1'b1, 1'b0, '0};
		plan[12] = '{1'b1, CMD_STOP, 8'h00, 1'b0, SDA_RAND, 1'b1, 1'b0, '0};
		plan[13] = '{1'b0, CMD_READ, 8'hFF, 1'b1, SDA_RAND, 1'b0, 1'b0, '0};

		// upper bits beyond the hold width must be dropped, zero acts as one
		sched[0] = '{32'd1, 32'd1, 3, ANY_CMD};
		sched[1] = '{32'hFFFF_0000, 32'h0001_0003, 1, ANY_CMD};
		sched[2] = '{32'd2, 32'd1, 1, ANY_CMD};
		sched[3] = '{32'd1, 32'd2, 1, ANY_CMD};
		sched[4] = '{32'd1, 32'd9, 1, ONLY_READ};
		sched[5] = '{32'd65535, 32'd1, 2, START_STOP};
		sched[6] = '{32'd2, 32'd5, 1, ANY_CMD};
		sched[7] = '{32'd3, 32'd2, 1, ANY_CMD};
		sched[8] = '{32'd1, 32'd2, 2, ANY_CMD};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < 14; i++) begin
			row = plan[i];
			t.cv = row.offer;
			t.req = row.req;
			t.wd = row.wd;
			t.ack = row.ack;
			t.sda = (row.sda_mode == SDA_RAND) ? 1'($urandom_range(1)) : row.sda_mode[0];
			push_tick(t, row.typed, row.want);
			while (ph != PH_IDLE) begin
				t.cv = row.noise ? 1'($urandom_range(1)) : 1'b0;
				t.req = 2'($urandom_range(3));
				t.wd = 8'($urandom_range(255));
				t.ack = 1'($urandom_range(1));
				if (row.sda_mode == SDA_RAND)
					t.sda = 1'($urandom_range(1));
				push_tick(t, row.typed, row.want);
			end
		end

		for (int p = 0; p < 9; p++) begin
			send_idle_pct = (p < 3) ? 28 : (p < 6) ? 45 : 0;
			recv_idle_pct = (p < 3) ? 45 : (p < 6) ? 28 : 0;
			// hold the tick channel until every line state is back
			tick_valid <= 1'b0;
			while (line_state_q.size() != 0)
				@(posedge clk);
			cfg_write(REG_SHORT_HOLD, sched[p].short_raw);
			cfg_write(REG_LONG_HOLD, sched[p].long_raw);
			taken = 0;
			while (taken < sched[p].ncmd) begin
				idle_now = (ph == PH_IDLE);
				t.cv = idle_now ? ($urandom_range(9) < 7) : ($urandom_range(9) == 0);
				do
					t.req = 2'($urandom_range(3));
				while (!sched[p].mask[t.req]);
				t.wd = 8'($urandom_range(255));
				t.ack = 1'($urandom_range(1));
				t.sda = 1'($urandom_range(1));
				push_tick(t, 1'b0, '0);
				if (idle_now && t.cv)
					taken++;
			end
			// run the last command out before touching the hold counts
			while (ph != PH_IDLE) begin
				t.cv = 1'b0;
				t.sda = 1'($urandom_range(1));
				push_tick(t, 1'b0, '0);
			end
		end

		tick_valid <= 1'b0;
		while (line_state_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
